// ===== design/mssu_pkg.sv =====
`default_nettype none

package mssu_pkg;

  localparam int unsigned NumDigitsDef = 4;
  localparam int unsigned QDepth       = 2;

  localparam logic [1:0] ReqShowTime  = 2'd0;
  localparam logic [1:0] ReqShowDigit = 2'd1;
  localparam logic [1:0] ReqScanTick  = 2'd2;

  localparam logic [3:0]  BlankCode   = 4'd15;
  localparam logic [3:0]  MaxDigit    = 4'd9;
  localparam logic [9:0]  MaxTenths   = 10'd999;
  localparam logic [31:0] SatMs       = 32'd99900;
  localparam logic [17:0] RecipTenth  = 18'd167773;  // ceil(2^24 / 100)
  localparam int unsigned RecipShift  = 24;
  localparam logic [7:0]  RecipTen    = 8'd205;      // (n * 205) >> 11 == n / 10
  localparam int unsigned RecipTenSh  = 11;
  localparam int unsigned PointPos    = 2;
  localparam logic [7:0]  DpBit       = 8'h80;
  localparam logic [7:0]  SegOff      = 8'hFF;
  localparam int unsigned WordW       = 16;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] time_ms;
    logic [7:0]  digit_value;
  } in_item_t;

  typedef struct packed {
    logic serial_bit;
    logic latch_after;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [WordW-1:0]  word;
  } q_item_t;

  function automatic logic [7:0] seg_lookup(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hF8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = SegOff;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/mssu_front.sv =====
`default_nettype none

module mssu_front import mssu_pkg::*; #(
  parameter int unsigned NUM_DIGITS = NumDigitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_item_i,
  output logic          busy_o,
  output q_item_t       q_wr_o
);

  localparam int unsigned PosW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int unsigned ProdW = 17 + 18;

  logic [3:0]            digit_q [NUM_DIGITS];
  logic [3:0]            digit_d [NUM_DIGITS];
  logic [NUM_DIGITS-1:0] pmask_q, pmask_d;
  logic [PosW-1:0]       pos_q, pos_d;

  // show-time pipeline
  logic        v1_q, v2_q, v3_q;
  logic        sat1_q;
  logic [16:0] ms1_q;
  logic [9:0]  t2_q;
  logic [6:0]  sec3_q;
  logic [3:0]  rem3_q;

  logic [ProdW-1:0] prod;
  logic [17:0]      tp;
  logic [6:0]       sec;
  logic [14:0]      sp;
  logic [3:0]       tens, ones;
  logic [7:0]       dclamp;
  logic [3:0]       cur_digit;
  logic [7:0]       seg_byte;
  logic [7:0]       sel_byte;

  logic acc_time, acc_digit, acc_scan;

  assign acc_time  = in_valid_i && (in_item_i.req_type == ReqShowTime);
  assign acc_digit = in_valid_i && (in_item_i.req_type == ReqShowDigit);
  assign acc_scan  = in_valid_i && (in_item_i.req_type == ReqScanTick);

  assign busy_o = v1_q || v2_q || v3_q;

  assign prod = ProdW'(ms1_q) * ProdW'(RecipTenth);
  assign tp   = 18'(t2_q) * 18'(RecipTen);
  assign sec  = tp[RecipTenSh +: 7];
  assign sp   = 15'(sec3_q) * 15'(RecipTen);
  assign tens = sp[RecipTenSh +: 4];
  assign ones = 4'(sec3_q - 7'(tens) * 7'd10);

  assign dclamp = (in_item_i.digit_value > 8'(MaxDigit)) ? 8'(MaxDigit)
                                                        : in_item_i.digit_value;

  assign cur_digit = digit_q[pos_q];
  always_comb begin
    seg_byte = SegOff;
    if (cur_digit <= MaxDigit) begin
      seg_byte = seg_lookup(cur_digit);
      if (pmask_q[pos_q]) begin
        seg_byte = seg_byte & ~DpBit;
      end
    end
  end
  assign sel_byte = 8'd1 << pos_q;

  assign q_wr_o.valid = acc_scan;
  assign q_wr_o.word  = {seg_byte, sel_byte};

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digit_d[i] = digit_q[i];
    end
    pmask_d = pmask_q;
    pos_d   = pos_q;
    if (v3_q) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        case (i)
          0:       digit_d[i] = BlankCode;
          1:       digit_d[i] = rem3_q;
          2:       digit_d[i] = ones;
          3:       digit_d[i] = tens;
          default: digit_d[i] = digit_q[i];
        endcase
      end
      pmask_d = '0;
      if (PointPos < NUM_DIGITS) begin
        pmask_d = NUM_DIGITS'(1) << PointPos;
      end
    end else if (acc_digit) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_d[i] = (i == 0) ? dclamp[3:0] : BlankCode;
      end
      pmask_d = '0;
    end
    if (acc_scan) begin
      pos_d = (pos_q == PosW'(NUM_DIGITS - 1)) ? '0 : pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_q[i] <= BlankCode;
      end
      pmask_q <= '0;
      pos_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_q[i] <= digit_d[i];
      end
      pmask_q <= pmask_d;
      pos_q   <= pos_d;
      v1_q    <= acc_time;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_time) begin
      sat1_q <= (in_item_i.time_ms >= SatMs);
      ms1_q  <= in_item_i.time_ms[16:0];
    end
    if (v1_q) begin
      t2_q <= sat1_q ? MaxTenths : prod[RecipShift +: 10];
    end
    if (v2_q) begin
      sec3_q <= sec;
      rem3_q <= 4'(t2_q - 10'(sec) * 10'd10);
    end
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({v1_q, v2_q, v3_q}))
    else $error("more than one show-time request in flight");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !in_valid_i)
    else $error("item accepted while show-time update pending");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < NUM_DIGITS)
    else $error("scan position out of range");

endmodule

`default_nettype wire

// ===== design/mssu_fifo.sv =====
`default_nettype none

module mssu_fifo import mssu_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_item_t wr_i,
  input  wire logic    rd_i,
  output q_item_t      rd_o,
  output logic         full_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic [WordW-1:0] mem_q [QDepth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_rd;

  assign full_o     = (cnt_q == CntW'(QDepth));
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.word  = mem_q[rptr_q];
  assign do_rd      = rd_i && rd_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i.valid) begin
        wptr_q <= (wptr_q == PtrW'(QDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(QDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(wr_i.valid) - CntW'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      mem_q[wptr_q] <= wr_i.word;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i.valid)
    else $error("write to full queue");

endmodule

`default_nettype wire

// ===== design/mssu_back.sv =====
`default_nettype none

module mssu_back import mssu_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_item_t q_i,
  output logic         q_rd_o,
  input  wire logic    pop,
  output logic         empty,
  output out_item_t    out_item_o
);

  localparam int unsigned CntW = $clog2(WordW);

  logic             act_q;
  logic [CntW-1:0]  cnt_q;
  logic [WordW-1:0] sh_q;
  logic             last, take, load;

  assign last  = (cnt_q == CntW'(WordW - 1));
  assign take  = pop && act_q;
  assign load  = q_i.valid && (!act_q || (take && last));
  assign q_rd_o = load;

  assign empty                  = !act_q;
  assign out_item_o.serial_bit  = sh_q[WordW-1];
  assign out_item_o.latch_after = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (load) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (take) begin
        if (last) begin
          act_q <= 1'b0;
        end
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sh_q <= q_i.word;
    end else if (take) begin
      sh_q <= {sh_q[WordW-2:0], 1'b0};
    end
  end

  a_no_drop_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q && !last) |=> act_q)
    else $error("word dropped before its last bit");

  a_load_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && act_q) |-> (take && last))
    else $error("word loaded over an unfinished one");

endmodule

`default_nettype wire

// ===== design/multiplexed_seven_segment_scanner_unit.sv =====
`default_nettype none
// Output path: a scan tick's word is written into the queue when it is accepted, then
//   loaded into the output shifter once that is free; its first bit is then on the ports.
// Throughput: one result per cycle while pop is held and the shifter holds a word; a scan
//   tick gives 16 result bits from the output shifter. Show-digit updates the digits
//   directly; show-time holds full until its divide pipeline (v1_q, v2_q, v3_q) is through.
// Reset: asynchronous, active low; all digits blank, decimal points off, scan at 0.

module multiplexed_seven_segment_scanner_unit import mssu_pkg::*; #(
  parameter int unsigned NUM_DIGITS = NumDigitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item_i,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item_o
);

  logic    busy, q_full, q_rd, in_valid;
  q_item_t q_wr, q_rd_item;

  assign full     = busy || q_full;
  assign in_valid = push && !full;

  mssu_front #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_item_i  (in_item_i),
    .busy_o     (busy),
    .q_wr_o     (q_wr)
  );

  mssu_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .rd_i   (q_rd),
    .rd_o   (q_rd_item),
    .full_o (q_full)
  );

  mssu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_i        (q_rd_item),
    .q_rd_o     (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mssu_pkg::*;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int unsigned NumPos = NumDigitsDef;
  localparam int unsigned RandomItems = 120;
  localparam logic [7:0] SegPattern [0:9] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  class scan_scoreboard;
    logic [3:0] digit_code [NumPos];
    logic [7:0] dp_mask;
    int unsigned scan_pos;
    out_item_t pending_bits [$];
    int unsigned mismatches;

    function new();
      foreach (digit_code[i]) digit_code[i] = BlankCode;
      dp_mask = '0;
      scan_pos = 0;
      mismatches = 0;
    endfunction

    function void put_code(int unsigned pos, logic [3:0] code);
      if (pos < NumPos) digit_code[pos] = code;
    endfunction

    function void note_item(in_item_t it);
      logic [31:0] tenths;
      logic [31:0] secs;
      logic [7:0] dv;
      logic [7:0] seg;
      logic [15:0] word;
      int unsigned pos;
      out_item_t bit_item;
      case (it.req_type)
        ReqShowTime: begin
          tenths = it.time_ms / 100;
          if (tenths > 999) tenths = 999;
          secs = tenths / 10;
          put_code(3, 4'(secs / 10));
          put_code(2, 4'(secs % 10));
          put_code(1, 4'(tenths % 10));
          put_code(0, BlankCode);
          dp_mask = 8'(1 << PointPos);
        end
        ReqShowDigit: begin
          dv = (it.digit_value > 8'd9) ? 8'd9 : it.digit_value;
          put_code(0, dv[3:0]);
          for (int unsigned i = 1; i < NumPos; i++) put_code(i, BlankCode);
          dp_mask = '0;
        end
        ReqScanTick: begin
          pos = (scan_pos >= NumPos) ? 0 : scan_pos;
          seg = 8'hFF;
          if (digit_code[pos] <= 4'd9) begin
            seg = SegPattern[digit_code[pos]];
            if (dp_mask[pos]) seg = seg & ~8'h80;
          end
          word = {seg, 8'(1 << pos)};
          for (int k = 15; k >= 0; k--) begin
            bit_item.serial_bit = word[k];
            bit_item.latch_after = (k == 0);
            pending_bits.push_back(bit_item);
          end
          scan_pos = (pos + 1 >= NumPos) ? 0 : pos + 1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_bits.size() == 0) begin
        $error("unexpected item: serial_bit %0b latch_after %0b",
               got.serial_bit, got.latch_after);
        mismatches++;
        return;
      end
      want = pending_bits.pop_front();
      if (got.serial_bit !== want.serial_bit) begin
        $error("serial_bit: expected %0b, got %0b", want.serial_bit, got.serial_bit);
        mismatches++;
      end
      if (got.latch_after !== want.latch_after) begin
        $error("latch_after: expected %0b, got %0b", want.latch_after, got.latch_after);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  in_item_t in_item;
  logic empty;
  logic pop;
  out_item_t out_item;
  logic steady;
  int unsigned sent;
  scan_scoreboard book;

  multiplexed_seven_segment_scanner_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      pop <= steady || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) book.check_result(out_item);
  end

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 37) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    book.note_item(it);
    if (it.req_type != ReqUnused) sent++;
  endtask

  task automatic send_req(input logic [1:0] req, input logic [31:0] ms,
                          input logic [7:0] dv);
    in_item_t it;
    it.req_type = req;
    it.time_ms = ms;
    it.digit_value = dv;
    send_item(it);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_req(ReqScanTick, $urandom, 8'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (book.pending_bits.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned goal;
    book = new();
    rst_n = 1'b0;
    push = 1'b0;
    in_item = '0;
    steady = 1'b0;
    sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: blank display, zero, saturation, just below saturation, clamps
    send_ticks(1);
    send_req(ReqShowTime, 32'd0, 8'd0);
    send_ticks(4);
    send_req(ReqShowTime, 32'hFFFF_FFFF, 8'hFF);
    send_ticks(4);
    send_req(ReqShowTime, 32'd99899, 8'd0);
    send_ticks(4);
    send_req(ReqShowDigit, 32'hFFFF_FFFF, 8'd255);
    send_ticks(4);
    send_req(ReqShowDigit, 32'd0, 8'd10);
    send_req(ReqUnused, 32'hFFFF_FFFF, 8'hFF);
    send_req(ReqShowDigit, 32'd0, 8'd0);
    send_ticks(4);
    wait_drained();

    goal = sent + RandomItems;
    while (sent < goal) begin
      steady = (sent >= goal - 100) && (sent < goal - 65);
      if (sent >= goal - 50 && sent < goal - 40 && book.pending_bits.size() != 0)
        wait_drained();
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(99) < 60)
          send_req(ReqShowTime,
                   ($urandom_range(99) < 75) ? 32'($urandom_range(0, 120000)) : $urandom,
                   8'($urandom));
        else
          send_req(ReqShowDigit, $urandom,
                   ($urandom_range(99) < 70) ? 8'($urandom_range(0, 15)) : 8'($urandom));
        send_ticks($urandom_range(NumPos, 2 * NumPos));
      end else begin
        send_req(2'($urandom_range(0, 3)), $urandom, 8'($urandom));
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (book.mismatches == 0 && book.pending_bits.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
